// ===== rtl/core/decimal_text_to_fixed_point_macros.svh =====
// Assertion macros for the decimal text to fixed point block.
// Used by the top level only; expects clk and rst_n in the calling scope.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH
`ifndef SYNTHESIS
`define DTFX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtfx assertion failed");
`define DTFX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtfx assertion failed");
`else
`define DTFX_ASSERT_NOW(label, ante, cons)
`define DTFX_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/dtfx_pkg.sv =====
// Shared types, constants and the fraction scale table of the decimal text parser.
// No dependencies; imported by every module of the block.
package dtfx_pkg;

  localparam int INT_BITS_DEF  = 40;
  localparam int FRAC_BITS_DEF = 24;
  localparam int VAL_W         = 64;
  localparam int FSUM_W        = 48;
  localparam int SCALE_W       = 29;
  localparam int DIGIT_W       = 9;
  localparam int FCNT_W        = 4;
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  localparam logic [FCNT_W-1:0] FRAC_DIGITS_MAX = 4'd10;

  typedef enum logic [1:0] {
    KIND_INT,
    KIND_FRAC,
    KIND_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t                   kind;
    logic signed [DIGIT_W-1:0]  digit;
    logic [FCNT_W-1:0]          frac_idx;
    logic                       negative;
  } op_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic st_valid;
    logic st_ready;
  } back_stat_t;

  // Scale of the k-th fraction digit in Q0.32, each step (prev + 5) / 10.
  function automatic logic [SCALE_W-1:0] frac_scale(input logic [FCNT_W-1:0] idx);
    logic [SCALE_W-1:0] s;
    s = '0;
    unique case (idx)
      4'd1:    s = 29'd429496730;
      4'd2:    s = 29'd42949673;
      4'd3:    s = 29'd4294967;
      4'd4:    s = 29'd429497;
      4'd5:    s = 29'd42950;
      4'd6:    s = 29'd4295;
      4'd7:    s = 29'd430;
      4'd8:    s = 29'd43;
      4'd9:    s = 29'd4;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/dtfx_front.sv =====
// Front end: accepts text bytes, tracks the parse phase, sign and fraction position.
// Depends on dtfx_pkg; pushes digit and end operations into dtfx_queue.
module dtfx_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_char,
  output logic                in_ready,
  input  logic                q_full,
  output logic                push,
  output dtfx_pkg::op_entry_t push_entry
);
  import dtfx_pkg::*;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_INT,
    PH_FRAC
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic                neg_r, neg_nxt;
  logic [FCNT_W-1:0]   fcnt_r, fcnt_nxt;
  logic                accept;
  logic                is_space;
  logic signed [DIGIT_W-1:0] digit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_space = ((in_char >= CH_TAB) && (in_char <= CH_CR)) || (in_char == CH_SPACE);
  assign digit    = $signed({1'b0, in_char} - {1'b0, CH_ZERO});

  always_comb begin
    phase_nxt           = phase_r;
    neg_nxt             = neg_r;
    fcnt_nxt            = fcnt_r;
    push                = 1'b0;
    push_entry.kind     = KIND_INT;
    push_entry.digit    = digit;
    push_entry.frac_idx = fcnt_r;
    push_entry.negative = neg_r;
    if (accept) begin
      if (in_char == CH_NUL) begin
        push            = 1'b1;
        push_entry.kind = KIND_END;
        phase_nxt       = PH_SPACE;
        neg_nxt         = 1'b0;
        fcnt_nxt        = '0;
      end else begin
        unique case (phase_r) inside
          PH_SPACE, PH_SIGN: begin
            if ((phase_r == PH_SPACE) && is_space) begin
              phase_nxt = PH_SPACE;
            end else if ((in_char == CH_PLUS) || (in_char == CH_MINUS)) begin
              phase_nxt = PH_SIGN;
              if (in_char == CH_MINUS) begin
                neg_nxt = !neg_r;
              end
            end else if (in_char == CH_DOT) begin
              phase_nxt = PH_FRAC;
            end else begin
              phase_nxt = PH_INT;
              push      = 1'b1;
            end
          end
          PH_INT: begin
            if (in_char == CH_DOT) begin
              phase_nxt = PH_FRAC;
            end else begin
              push = 1'b1;
            end
          end
          PH_FRAC: begin
            if (fcnt_r != FRAC_DIGITS_MAX) begin
              fcnt_nxt = fcnt_r + 1'b1;
            end
            push                = 1'b1;
            push_entry.kind     = KIND_FRAC;
            push_entry.frac_idx = fcnt_nxt;
          end
          default: phase_nxt = PH_SPACE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      neg_r   <= 1'b0;
      fcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      fcnt_r  <= fcnt_nxt;
    end
  end

endmodule

// ===== rtl/core/dtfx_queue.sv =====
// Short operation queue between the front end and the arithmetic back end.
// Depends on dtfx_pkg for the entry type and depth.
module dtfx_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dtfx_pkg::op_entry_t push_entry,
  input  logic                pop,
  output dtfx_pkg::op_entry_t head,
  output dtfx_pkg::q_stat_t   stat
);
  import dtfx_pkg::*;

  op_entry_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr_r, rptr_r;
  logic [Q_PTR_W:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == (Q_PTR_W + 1)'(Q_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign head       = mem_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wptr_r <= (wptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/dtfx_back.sv =====
// Back end: integer and fraction accumulators, result assembly and output register.
// Depends on dtfx_pkg; takes operations from dtfx_queue.
module dtfx_back #(
  parameter int INT_BITS  = dtfx_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS = dtfx_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dtfx_pkg::op_entry_t             head,
  input  dtfx_pkg::q_stat_t               q_stat,
  output logic                            pop,
  output dtfx_pkg::back_stat_t            stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dtfx_pkg::VAL_W-1:0]      out_value,
  output logic                            out_ovf
);
  import dtfx_pkg::*;

  localparam int SH  = 32 - FRAC_BITS;
  localparam int TW  = INT_BITS + 5;
  localparam logic [FSUM_W-1:0] HALF = (FSUM_W'(1) << SH) >> 1;

  logic [INT_BITS-1:0]        int_r, int_nxt;
  logic signed [FSUM_W-1:0]   frac_r, frac_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [TW-1:0]              int_ext, int_step;
  logic [TW-INT_BITS:0]       int_top;
  logic signed [38:0]         prod;
  logic signed [FSUM_W-1:0]   frac_shift;
  logic [VAL_W-1:0]           sum_val;

  logic                       st_valid_r;
  logic [VAL_W-1:0]           st_sum_r;
  logic                       st_neg_r;
  logic                       st_ovf_r;
  logic                       st_ready, out_free;
  logic                       take_end;

  logic                       out_valid_r;
  logic [VAL_W-1:0]           out_value_r;
  logic                       out_ovf_r;

  assign out_free = !out_valid_r || out_ready;
  assign st_ready = !st_valid_r || out_free;
  assign pop      = q_stat.valid && ((head.kind != KIND_END) || st_ready);
  assign take_end = pop && (head.kind == KIND_END);

  assign stat.st_valid = st_valid_r;
  assign stat.st_ready = st_ready;

  assign int_ext  = {{5{int_r[INT_BITS-1]}}, int_r};
  assign int_step = (int_ext << 3) + (int_ext << 1)
                  + {{(TW-DIGIT_W){head.digit[DIGIT_W-1]}}, head.digit};
  assign int_top  = int_step[TW-1:INT_BITS-1];

  assign prod = 39'(head.digit) * 39'($signed({1'b0, frac_scale(head.frac_idx)}));

  assign frac_shift = frac_r >>> SH;
  assign sum_val = ({{(VAL_W-INT_BITS){int_r[INT_BITS-1]}}, int_r} << FRAC_BITS)
                 + {{(VAL_W-FSUM_W){frac_shift[FSUM_W-1]}}, frac_shift};

  always_comb begin
    int_nxt  = int_r;
    frac_nxt = frac_r;
    ovf_nxt  = ovf_r;
    if (pop) begin
      case (head.kind)
        KIND_INT: begin
          int_nxt = int_step[INT_BITS-1:0];
          if (!((&int_top) || !(|int_top))) begin
            ovf_nxt = 1'b1;
          end
        end
        KIND_FRAC: begin
          frac_nxt = frac_r + {{(FSUM_W-39){prod[38]}}, prod};
        end
        default: begin
          int_nxt  = '0;
          frac_nxt = $signed(HALF);
          ovf_nxt  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r       <= '0;
      frac_r      <= $signed(HALF);
      ovf_r       <= 1'b0;
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      int_r  <= int_nxt;
      frac_r <= frac_nxt;
      ovf_r  <= ovf_nxt;
      if (st_ready) begin
        st_valid_r <= take_end;
      end
      if (out_free) begin
        out_valid_r <= st_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_end) begin
      st_sum_r <= sum_val;
      st_neg_r <= head.negative;
      st_ovf_r <= ovf_r;
    end
    if (out_free && st_valid_r) begin
      out_value_r <= st_neg_r ? (VAL_W'(0) - st_sum_r) : st_sum_r;
      out_ovf_r   <= st_ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_ovf   = out_ovf_r;

endmodule

// ===== rtl/core/decimal_text_to_fixed_point.sv =====
// Decimal text to signed fixed point converter.
// A byte-wide input stream carries text one character per beat. A zero byte
// ends the number and produces one result beat; no other byte produces output.
// The result carries the value in tdata (64-bit two's complement with FRAC_BITS
// fraction bits) and the integer overflow flag in tuser.
// Throughput is one input beat per cycle while in_tready is high: the front end
// classifies each byte in the cycle it is accepted, and the back end applies
// one digit per cycle with a single constant multiply by ten and one
// digit-by-scale product. A result goes through the stage and output registers.
// When the receiver holds out_tready low, up to two results wait in the output
// pipeline and the operation queue fills; in_tready then drops until the
// output drains. Digit bytes keep flowing while a result waits.
// Reset clears the parse state, the queue and the output pipeline; no result
// is pending afterwards and the next byte starts a new number.
module decimal_text_to_fixed_point #(
  parameter int INT_BITS  = dtfx_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS = dtfx_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] character
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [dtfx_pkg::VAL_W-1:0]   out_tdata,  // [63:0] value
  output logic                         out_tuser   // [0] overflow
);
  import dtfx_pkg::*;

`include "decimal_text_to_fixed_point_macros.svh"

  logic        push, pop;
  op_entry_t   push_entry, head;
  q_stat_t     q_stat;
  back_stat_t  b_stat;

  dtfx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_char    (in_tdata),
    .in_ready   (in_tready),
    .q_full     (q_stat.full),
    .push       (push),
    .push_entry (push_entry)
  );

  dtfx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  dtfx_back #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .stat      (b_stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (out_tdata),
    .out_ovf   (out_tuser)
  );

  `DTFX_ASSERT_NOW(a_full_holds_end, q_stat.full, head.kind == KIND_END)
  `DTFX_ASSERT_NEXT(a_stage_refills, b_stat.st_valid && (!out_tvalid || out_tready), out_tvalid)
  `DTFX_ASSERT_NOW(a_pop_only_valid, pop, q_stat.valid)
  `DTFX_ASSERT_NOW(a_end_has_room, pop && (head.kind == KIND_END), b_stat.st_ready)

endmodule

// ===== tb/decimal_text_to_fixed_point_tb.sv =====
// Self-checking testbench for decimal_text_to_fixed_point: streams number text into the block
// and checks each result beat with an in-bench model of the same arithmetic or a typed value.
// Depends on dtfx_pkg and the decimal_text_to_fixed_point RTL only.
`timescale 1ns / 100ps

module decimal_text_to_fixed_point_tb;

  localparam int INT_BITS  = dtfx_pkg::INT_BITS_DEF;
  localparam int FRAC_BITS = dtfx_pkg::FRAC_BITS_DEF;
  localparam int ROUND_SH  = 32 - FRAC_BITS;
  localparam longint INT_HI = (longint'(1) <<< (INT_BITS - 1)) - 1;
  localparam longint INT_LO = -INT_HI - 1;
  localparam logic [63:0] SCALE_ONE = 64'd1 << 32;
  localparam int RANDOM_CHARS = 1600;

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_SIGN,
    PH_INT,
    PH_FRAC
  } parse_phase_t;

  typedef struct packed {
    logic [63:0] value;
    logic        overflow;
  } parsed_number_t;

  typedef struct {
    string       text;
    bit          typed;
    logic [63:0] value;
    logic        overflow;
  } text_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;

  parse_phase_t   num_phase;
  bit             num_negative;
  longint         int_acc;
  longint         frac_acc;
  logic [63:0]    digit_weight;
  bit             int_wrapped;
  parsed_number_t pending_numbers[$];

  int error_count = 0;
  int chars_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  text_row_t directed_rows [5] = '{
    '{"", 1'b1, 64'd0, 1'b0},
    '{"\t\r +-7", 1'b1, 64'hFFFF_FFFF_F900_0000, 1'b0},
    '{"0.5", 1'b1, 64'h0000_0000_0080_0000, 1'b0},
    '{"\377\377\377\377\377\377\377\377\377\377\377\377", 1'b0, 64'd0, 1'b0},
    '{"9..", 1'b0, 64'd0, 1'b0}
  };

  decimal_text_to_fixed_point #(
    .INT_BITS (INT_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  task automatic clear_number();
    num_phase    = PH_SPACE;
    num_negative = 1'b0;
    int_acc      = 0;
    frac_acc     = 0;
    digit_weight = SCALE_ONE;
    int_wrapped  = 1'b0;
  endtask

  task automatic parse_character(input logic [7:0] c, output bit emitted,
                                 output parsed_number_t num);
    longint digit;
    longint t;
    longint rounded;
    longint v;
    digit   = longint'({56'd0, c}) - longint'({56'd0, dtfx_pkg::CH_ZERO});
    emitted = 1'b0;
    num     = '0;
    if (c == dtfx_pkg::CH_NUL) begin
      rounded = (ROUND_SH > 0) ? ((frac_acc + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH)
                               : frac_acc;
      v = (int_acc <<< FRAC_BITS) + rounded;
      if (num_negative) begin
        v = -v;
      end
      emitted      = 1'b1;
      num.value    = v;
      num.overflow = int_wrapped;
      clear_number();
      return;
    end
    if (num_phase == PH_SPACE) begin
      if ((c >= dtfx_pkg::CH_TAB && c <= dtfx_pkg::CH_CR) || c == dtfx_pkg::CH_SPACE) begin
        return;
      end
      num_phase = PH_SIGN;
    end
    if (num_phase == PH_SIGN) begin
      if (c == dtfx_pkg::CH_PLUS || c == dtfx_pkg::CH_MINUS) begin
        if (c == dtfx_pkg::CH_MINUS) begin
          num_negative = !num_negative;
        end
        return;
      end
      num_phase = PH_INT;
    end
    if (num_phase == PH_INT) begin
      if (c == dtfx_pkg::CH_DOT) begin
        num_phase = PH_FRAC;
      end else begin
        t = int_acc * 10 + digit;
        if (t > INT_HI || t < INT_LO) begin
          int_wrapped = 1'b1;
        end
        int_acc = (t <<< (64 - INT_BITS)) >>> (64 - INT_BITS);
      end
      return;
    end
    digit_weight = (digit_weight + 64'd5) / 64'd10;
    frac_acc     = frac_acc + digit * $signed(digit_weight);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s at %0t: got %h, expected %h", what, $realtime, got, want);
    error_count++;
  endtask

  // One character beat; the expectation is queued at the edge that accepts it.
  task automatic send_character(input logic [7:0] c, input bit typed = 1'b0,
                                input parsed_number_t typed_num = '0);
    bit             emitted;
    parsed_number_t num;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    parse_character(c, emitted, num);
    if (emitted) begin
      pending_numbers.push_back(typed ? typed_num : num);
    end
    chars_sent++;
  endtask

  function automatic logic [7:0] any_text_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] decimal_digit();
    return dtfx_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic send_random_number();
    logic [7:0] text[$];
    int         n;
    int         int_len;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(0, 8);
      repeat (n) text.push_back(any_text_byte());
    end else begin
      n = $urandom_range(0, 3);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0:       text.push_back(dtfx_pkg::CH_SPACE);
          1:       text.push_back(dtfx_pkg::CH_TAB + 8'($urandom_range(0, 4)));
          default: text.push_back(dtfx_pkg::CH_SPACE);
        endcase
      end
      n = $urandom_range(0, 3);
      repeat (n) text.push_back($urandom_range(0, 1) ? dtfx_pkg::CH_MINUS : dtfx_pkg::CH_PLUS);
      int_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 6);
      repeat (int_len) text.push_back(decimal_digit());
      if ($urandom_range(0, 3) != 0) begin
        text.push_back(dtfx_pkg::CH_DOT);
        n = $urandom_range(0, 12);
        repeat (n) text.push_back(decimal_digit());
      end
      foreach (text[i]) begin
        if ($urandom_range(0, 99) < 6) begin
          text[i] = any_text_byte();
        end
      end
    end
    foreach (text[i]) send_character(text[i]);
    send_character(dtfx_pkg::CH_NUL);
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    parsed_number_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_numbers.size() == 0) begin
        report_mismatch("unexpected result beat", out_tdata, 64'd0);
      end else begin
        want = pending_numbers.pop_front();
        if (out_tdata !== want.value) begin
          report_mismatch("value", out_tdata, want.value);
        end
        if (out_tuser !== want.overflow) begin
          report_mismatch("overflow", {63'd0, out_tuser}, {63'd0, want.overflow});
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    parsed_number_t typed_num;
    clear_number();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].text.len(); i++) begin
        send_character(directed_rows[r].text[i]);
      end
      typed_num.value    = directed_rows[r].value;
      typed_num.overflow = directed_rows[r].overflow;
      send_character(dtfx_pkg::CH_NUL, directed_rows[r].typed, typed_num);
    end

    chars_sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 1) begin
        send_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (20) send_random_number();
        send_idle_pct = 65;
      end
      while (chars_sent < RANDOM_CHARS * (ph + 1) / 3) begin
        send_random_number();
      end
      if (ph == 1) begin
        in_tvalid <= 1'b0;
        while (pending_numbers.size() != 0) @(posedge clk);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
